// File: hw/rtl/fully_assoc_cache_lru_tags_defines.svh
// Assertion helpers for the fully associative tag store.
`ifndef FULLY_ASSOC_CACHE_LRU_TAGS_DEFINES_SVH
`define FULLY_ASSOC_CACHE_LRU_TAGS_DEFINES_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define FALRU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define FALRU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/falru_pkg.sv
package falru_pkg;

  localparam int WAYS        = 128;
  localparam int OFFSET_BITS = 4;
  localparam int ADDR_BITS   = 16;
  localparam int WAY_W       = $clog2(WAYS);
  localparam int TAG_W       = ADDR_BITS - OFFSET_BITS;
  localparam int WAY_OUT_W   = 7;
  localparam int CNT_W       = 32;

  typedef struct packed {
    logic [WAY_W-1:0] way;
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic             dirty;
  } entry_t;

  typedef struct packed {
    logic             capture;
    logic [TAG_W-1:0] tag;
    logic [WAY_W-1:0] fill_way;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/falru_if.sv
interface falru_req_if;
  logic                             valid;
  logic                             ready;
  logic [falru_pkg::ADDR_BITS-1:0]  address;
  logic                             is_write;

  modport source (output valid, address, is_write, input ready);
  modport sink   (input valid, address, is_write, output ready);
endinterface

interface falru_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic [falru_pkg::WAY_OUT_W-1:0]  way_index;
  logic [falru_pkg::CNT_W-1:0]      accesses_so_far;
  logic [falru_pkg::CNT_W-1:0]      misses_so_far;
  logic [falru_pkg::CNT_W-1:0]      read_misses_so_far;
  logic [falru_pkg::CNT_W-1:0]      write_misses_so_far;

  modport source (output valid, hit, way_index, accesses_so_far, misses_so_far,
                  read_misses_so_far, write_misses_so_far, input ready);
  modport sink   (input valid, hit, way_index, accesses_so_far, misses_so_far,
                  read_misses_so_far, write_misses_so_far, output ready);
endinterface

// File: hw/rtl/falru_cell.sv
// One slot of the recency stack: holds an entry, compares its tag, and takes
// the entry of its upper neighbor when told to shift.
module falru_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [falru_pkg::WAY_W-1:0] init_way_i,
  input  falru_pkg::cell_ctrl_t       ctrl_i,
  input  logic                        shift_i,
  input  falru_pkg::entry_t           prev_i,
  output falru_pkg::entry_t           entry_o,
  output logic                        hit_o,
  output logic                        fill_o
);

  logic [falru_pkg::WAY_W-1:0] way_q;
  logic [falru_pkg::TAG_W-1:0] tag_q;
  logic                        valid_q;
  logic                        dirty_q;
  logic                        hit_q;
  logic                        fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      way_q   <= init_way_i;
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
    end else if (shift_i) begin
      way_q   <= prev_i.way;
      valid_q <= prev_i.valid;
      dirty_q <= prev_i.dirty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      tag_q <= prev_i.tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      fill_q <= 1'b0;
    end else if (ctrl_i.capture) begin
      hit_q  <= valid_q && (tag_q == ctrl_i.tag);
      fill_q <= (way_q == ctrl_i.fill_way);
    end
  end

  assign entry_o.way   = way_q;
  assign entry_o.tag   = tag_q;
  assign entry_o.valid = valid_q;
  assign entry_o.dirty = dirty_q;
  assign hit_o         = hit_q;
  assign fill_o        = fill_q;

endmodule

// File: hw/rtl/fully_assoc_cache_lru_tags.sv
// Tag store of a 128-way fully associative cache with true LRU replacement.
// The ways sit in a row of cells ordered by recency, most recent first; every
// cell compares its tag against the access in parallel. An access has two
// steps: on accept the cells latch their per-cell hit and fill-target matches;
// on completion in ST_UPD the cells above the chosen one shift down by one slot,
// the chosen way is written to the top of the row, the saturating counters bump
// and the result register loads. A new access is taken only once the previous
// one has completed; a held result stalls completion of the next access. Ways
// fill in index order, so the lowest invalid way is the fill count, and once all
// are valid the victim is the last cell of the row.
`include "fully_assoc_cache_lru_tags_defines.svh"

module fully_assoc_cache_lru_tags (
  input  logic               clk_i,
  input  logic               rst_ni,
  falru_req_if.sink          req_i,
  falru_rsp_if.source        rsp_o
);

  localparam int WAYS  = falru_pkg::WAYS;
  localparam int WAY_W = falru_pkg::WAY_W;
  localparam int CNT_W = falru_pkg::CNT_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_UPD  = 2'b10
  } state_e;

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

  // Bit k set when any bit at k or above is set.
  function automatic logic [WAYS-1:0] suffix_or(logic [WAYS-1:0] v);
    logic [WAYS-1:0] s;
    s = v;
    for (int d = 1; d < WAYS; d = d * 2) begin
      s = s | (s >> d);
    end
    return s;
  endfunction

  state_e                      state_q, state_d;
  logic [falru_pkg::TAG_W-1:0] tag_q;
  logic                        wr_q;
  logic [WAY_W:0]              fill_cnt_q, fill_cnt_d;
  logic [CNT_W-1:0]            acc_q, acc_d, miss_q, miss_d;
  logic [CNT_W-1:0]            rmiss_q, rmiss_d, wmiss_q, wmiss_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_hit_q;
  logic [WAY_W-1:0]            out_way_q;

  falru_pkg::entry_t     cells   [WAYS];
  logic [WAYS-1:0]       hit_vec;
  logic [WAYS-1:0]       fill_vec;
  logic [WAYS-1:0]       shift_vec;
  logic [WAYS-1:0]       sel;
  falru_pkg::cell_ctrl_t ctrl;
  falru_pkg::entry_t     new_entry;

  logic             accept;
  logic             done;
  logic             any_hit;
  logic             full;
  logic [WAY_W-1:0] sel_way;
  logic             sel_dirty;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign done        = (state_q == ST_UPD) && (!out_valid_q || rsp_o.ready);
  assign full        = (fill_cnt_q == (WAY_W + 1)'(WAYS));
  assign any_hit     = |hit_vec;

  assign ctrl.capture  = accept;
  assign ctrl.tag      = req_i.address[falru_pkg::ADDR_BITS-1:falru_pkg::OFFSET_BITS];
  assign ctrl.fill_way = fill_cnt_q[WAY_W-1:0];

  always_comb begin
    priority if (any_hit) begin
      sel = hit_vec;
    end else if (full) begin
      sel = {1'b1, {(WAYS - 1){1'b0}}};
    end else begin
      sel = fill_vec;
    end
  end

  always_comb begin
    sel_way   = '0;
    sel_dirty = 1'b0;
    for (int k = 0; k < WAYS; k++) begin
      sel_way   = sel_way | ({WAY_W{sel[k]}} & cells[k].way);
      sel_dirty = sel_dirty | (sel[k] & cells[k].dirty);
    end
  end

  assign new_entry.way   = sel_way;
  assign new_entry.tag   = tag_q;
  assign new_entry.valid = 1'b1;
  assign new_entry.dirty = any_hit ? (sel_dirty | wr_q) : wr_q;

  // Cells from the top down to the chosen one move down one slot.
  assign shift_vec = {WAYS{done}} & suffix_or(sel);

  for (genvar k = 0; k < WAYS; k++) begin : g_cell
    falru_pkg::entry_t prev;
    if (k == 0) begin : g_head
      assign prev = new_entry;
    end else begin : g_body
      assign prev = cells[k-1];
    end

    falru_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .init_way_i (WAY_W'(WAYS - 1 - k)),
      .ctrl_i     (ctrl),
      .shift_i    (shift_vec[k]),
      .prev_i     (prev),
      .entry_o    (cells[k]),
      .hit_o      (hit_vec[k]),
      .fill_o     (fill_vec[k])
    );
  end

  always_comb begin
    state_d     = state_q;
    fill_cnt_d  = fill_cnt_q;
    acc_d       = acc_q;
    miss_d      = miss_q;
    rmiss_d     = rmiss_q;
    wmiss_d     = wmiss_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (done) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          acc_d       = sat_inc(acc_q);
          if (!any_hit) begin
            miss_d = sat_inc(miss_q);
            if (wr_q) begin
              wmiss_d = sat_inc(wmiss_q);
            end else begin
              rmiss_d = sat_inc(rmiss_q);
            end
            if (!full) begin
              fill_cnt_d = fill_cnt_q + (WAY_W + 1)'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_cnt_q  <= '0;
      acc_q       <= '0;
      miss_q      <= '0;
      rmiss_q     <= '0;
      wmiss_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_cnt_q  <= fill_cnt_d;
      acc_q       <= acc_d;
      miss_q      <= miss_d;
      rmiss_q     <= rmiss_d;
      wmiss_q     <= wmiss_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tag_q <= ctrl.tag;
      wr_q  <= req_i.is_write;
    end
    if (done) begin
      out_hit_q <= any_hit;
      out_way_q <= sel_way;
    end
  end

  assign rsp_o.valid               = out_valid_q;
  assign rsp_o.hit                 = out_hit_q;
  assign rsp_o.way_index           = falru_pkg::WAY_OUT_W'(out_way_q);
  assign rsp_o.accesses_so_far     = acc_q;
  assign rsp_o.misses_so_far       = miss_q;
  assign rsp_o.read_misses_so_far  = rmiss_q;
  assign rsp_o.write_misses_so_far = wmiss_q;

  `FALRU_ASSERT_IMP(a_hit_unique, state_q == ST_UPD, $onehot0(hit_vec), "tag hit in two ways")
  `FALRU_ASSERT_IMP(a_fill_unique, (state_q == ST_UPD) && !full, $onehot(fill_vec), "fill way not found once")
  `FALRU_ASSERT_NXT(a_done_result, done, out_valid_q && (state_q == ST_IDLE), "result beat not loaded")

endmodule

// File: tb/fully_assoc_cache_lru_tags_test.sv
`timescale 1ns / 1ps

module fully_assoc_cache_lru_tags_test;

  localparam int WAYS        = falru_pkg::WAYS;
  localparam int OFFSET_BITS = falru_pkg::OFFSET_BITS;
  localparam int ADDR_BITS   = falru_pkg::ADDR_BITS;
  localparam int WAY_W       = falru_pkg::WAY_W;
  localparam int TAG_W       = falru_pkg::TAG_W;
  localparam int WAY_OUT_W   = falru_pkg::WAY_OUT_W;
  localparam int CNT_W       = falru_pkg::CNT_W;

  localparam int DRAIN_CYCLES = 10;
  localparam int HISTORY_DEPTH = 200;
  localparam int RANDOM_ITEMS = 450;

  typedef struct packed {
    logic [ADDR_BITS-1:0] address;
    logic                 is_write;
  } access_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way_index;
    logic [CNT_W-1:0]     accesses;
    logic [CNT_W-1:0]     misses;
    logic [CNT_W-1:0]     read_misses;
    logic [CNT_W-1:0]     write_misses;
  } lookup_result_t;

  logic clk_i;
  logic rst_ni;

  falru_req_if req_bus ();
  falru_rsp_if rsp_bus ();

  fully_assoc_cache_lru_tags dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Shadow tag store
  logic             way_valid [WAYS];
  logic             way_dirty [WAYS];
  logic [TAG_W-1:0] way_tag   [WAYS];
  logic [WAY_W-1:0] way_rank  [WAYS];
  logic [CNT_W-1:0] access_count;
  logic [CNT_W-1:0] miss_count;
  logic [CNT_W-1:0] read_miss_count;
  logic [CNT_W-1:0] write_miss_count;

  access_t        access_q[$];
  lookup_result_t lookup_q[$];
  logic [TAG_W-1:0] recent_tags[$];

  access_t cur_access;
  logic    req_taken;
  logic    rsp_taken;
  int      req_gap;
  int      req_quiet;
  int      rsp_stall;
  int      rsp_quiet;
  int      accepted_count;
  int      total_accesses;
  int      mismatch_count;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void reset_tag_store();
    for (int i = 0; i < WAYS; i++) begin
      way_valid[i] = 1'b0;
      way_dirty[i] = 1'b0;
      way_tag[i]   = '0;
      way_rank[i]  = WAY_W'(i);
    end
    access_count     = '0;
    miss_count       = '0;
    read_miss_count  = '0;
    write_miss_count = '0;
  endfunction

  function automatic lookup_result_t lookup_and_update(input access_t acc);
    logic [TAG_W-1:0] tag;
    logic             found;
    int               way;
    logic [WAY_W-1:0] old_rank;
    lookup_result_t   res;
    tag   = acc.address[ADDR_BITS-1:OFFSET_BITS];
    found = 1'b0;
    way   = 0;
    access_count = sat_inc(access_count);
    for (int i = 0; i < WAYS; i++) begin
      if (!found && way_valid[i] && way_tag[i] == tag) begin
        found = 1'b1;
        way   = i;
      end
    end
    res.hit = found;
    if (found) begin
      if (acc.is_write) way_dirty[way] = 1'b1;
    end else begin
      miss_count = sat_inc(miss_count);
      if (acc.is_write) write_miss_count = sat_inc(write_miss_count);
      else read_miss_count = sat_inc(read_miss_count);
      // Lowest invalid way first, else the least recently used one
      way = -1;
      for (int i = 0; i < WAYS; i++) begin
        if (way < 0 && !way_valid[i]) way = i;
      end
      if (way < 0) begin
        for (int i = 0; i < WAYS; i++) begin
          if (way_rank[i] == '0) way = i;
        end
      end
      way_valid[way] = 1'b1;
      way_tag[way]   = tag;
      way_dirty[way] = acc.is_write;
    end
    old_rank = way_rank[way];
    for (int i = 0; i < WAYS; i++) begin
      if (way_rank[i] > old_rank) way_rank[i] = way_rank[i] - 1'b1;
    end
    way_rank[way] = WAY_W'(WAYS - 1);
    res.way_index    = WAY_OUT_W'(way);
    res.accesses     = access_count;
    res.misses       = miss_count;
    res.read_misses  = read_miss_count;
    res.write_misses = write_miss_count;
    return res;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a stretch of none
  function automatic int pick_gap(inout int quiet_left);
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) quiet_left = $urandom_range(20, 60);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  function automatic void queue_access(input logic [ADDR_BITS-1:0] addr, input logic wr);
    access_t acc;
    acc.address  = addr;
    acc.is_write = wr;
    access_q.push_back(acc);
    recent_tags.push_back(addr[ADDR_BITS-1:OFFSET_BITS]);
    if (recent_tags.size() > HISTORY_DEPTH) void'(recent_tags.pop_front());
  endfunction

  function automatic void report_mismatch(input string what, input lookup_result_t exp_r,
                                          input lookup_result_t got_r);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: expected hit=%0b way=%0d acc=%0d miss=%0d rmiss=%0d wmiss=%0d",
               $realtime, what, exp_r.hit, exp_r.way_index, exp_r.accesses,
               exp_r.misses, exp_r.read_misses, exp_r.write_misses);
      $display("%0t %s:   actual hit=%0b way=%0d acc=%0d miss=%0d rmiss=%0d wmiss=%0d",
               $realtime, what, got_r.hit, got_r.way_index, got_r.accesses,
               got_r.misses, got_r.read_misses, got_r.write_misses);
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!req_bus.valid || req_taken)) begin
      if (req_gap > 0) begin
        req_bus.valid <= 1'b0;
        req_gap--;
      end else if (access_q.size() > 0) begin
        cur_access = access_q.pop_front();
        req_bus.address  <= cur_access.address;
        req_bus.is_write <= cur_access.is_write;
        req_bus.valid    <= 1'b1;
        req_gap = pick_gap(req_quiet);
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Result back-pressure: hold ready low for a random stretch after each beat
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rsp_stall == 0 && rsp_taken) rsp_stall = pick_gap(rsp_quiet);
      if (rsp_stall > 0) begin
        rsp_bus.ready <= 1'b0;
        rsp_stall--;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Monitor: check results, then predict newly accepted accesses
  always @(posedge clk_i) begin
    lookup_result_t got_r;
    access_t        acc;
    if (rst_ni) begin
      req_taken <= req_bus.valid && req_bus.ready;
      rsp_taken <= rsp_bus.valid && rsp_bus.ready;
      if (rsp_bus.valid && rsp_bus.ready) begin
        got_r.hit          = rsp_bus.hit;
        got_r.way_index    = rsp_bus.way_index;
        got_r.accesses     = rsp_bus.accesses_so_far;
        got_r.misses       = rsp_bus.misses_so_far;
        got_r.read_misses  = rsp_bus.read_misses_so_far;
        got_r.write_misses = rsp_bus.write_misses_so_far;
        if (lookup_q.size() == 0) begin
          report_mismatch("unexpected beat", got_r, got_r);
        end else if (got_r !== lookup_q[0]) begin
          report_mismatch("mismatch", lookup_q[0], got_r);
          void'(lookup_q.pop_front());
        end else begin
          void'(lookup_q.pop_front());
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        acc.address  = req_bus.address;
        acc.is_write = req_bus.is_write;
        lookup_q.push_back(lookup_and_update(acc));
        accepted_count++;
      end
    end
  end

  initial begin
    int r;
    logic [TAG_W-1:0] tag;
    rst_ni           = 1'b0;
    req_bus.valid    = 1'b0;
    req_bus.address  = '0;
    req_bus.is_write = 1'b0;
    rsp_bus.ready    = 1'b0;
    req_taken        = 1'b0;
    rsp_taken        = 1'b0;
    req_gap          = 0;
    req_quiet        = 0;
    rsp_stall        = 0;
    rsp_quiet        = 0;
    accepted_count   = 0;
    mismatch_count   = 0;
    reset_tag_store();

    // Directed: address extremes, offset aliasing, read/write hits and misses
    queue_access(16'h0000, 1'b0);
    queue_access(16'h000F, 1'b0);
    queue_access(16'h0005, 1'b1);
    queue_access(16'hFFFF, 1'b1);
    queue_access(16'hFFF0, 1'b0);
    queue_access(16'h8000, 1'b0);
    queue_access(16'h7FF0, 1'b1);
    queue_access(16'h5555, 1'b0);
    queue_access(16'hAAAA, 1'b1);
    queue_access(16'h0010, 1'b0);
    queue_access(16'h0000, 1'b1);
    queue_access(16'h8009, 1'b1);
    queue_access(16'h7FFF, 1'b0);
    queue_access(16'h0013, 1'b1);
    queue_access(16'hFFF8, 1'b0);
    queue_access(16'h5550, 1'b1);

    // Random: reuse of recent tags for hits and near-LRU evictions, fresh
    // addresses to fill the store and force replacement
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        tag = recent_tags[$urandom_range(0, recent_tags.size() - 1)];
        queue_access({tag, OFFSET_BITS'($urandom)}, 1'($urandom));
      end else begin
        queue_access(ADDR_BITS'($urandom), 1'($urandom));
      end
    end
    total_accesses = access_q.size();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (accepted_count < total_accesses || lookup_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_count == 0 && lookup_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
